>>> sv/ssrv_pkg.sv
// Package with the shared types, constants and table functions of the swell reverb.
package ssrv_pkg;

   localparam int DEF_COMB_DEPTH    = 4096;
   localparam int DEF_ALLPASS_DEPTH = 1024;
   localparam int DEF_NUM_COMBS     = 4;
   localparam int DEF_NUM_ALLPASSES = 2;
   localparam int DEF_SAMPLE_BITS   = 24;

   localparam int IO_W   = 24;
   localparam int LVL_W  = 16;
   localparam int CFG_W  = 31;
   localparam int CIDX_W = 3;

   localparam logic [CIDX_W-1:0] CFG_ROOM      = 3'd0;
   localparam logic [CIDX_W-1:0] CFG_FEEDBACK  = 3'd1;
   localparam logic [CIDX_W-1:0] CFG_DAMPING   = 3'd2;
   localparam logic [CIDX_W-1:0] CFG_ATTACK    = 3'd3;
   localparam logic [CIDX_W-1:0] CFG_RELEASE   = 3'd4;
   localparam logic [CIDX_W-1:0] CFG_MODE      = 3'd5;
   localparam logic [CIDX_W-1:0] CFG_TAPE_COEF = 3'd6;

   localparam logic [14:0] RST_ROOM      = 15'd16384;
   localparam logic [14:0] RST_FEEDBACK  = 15'd29491;
   localparam logic [14:0] RST_DAMPING   = 15'd14746;
   localparam logic [30:0] RST_ATTACK    = 31'd2236962;
   localparam logic [30:0] RST_RELEASE   = 31'd8947849;
   localparam logic [2:0]  RST_MODE      = 3'd0;
   localparam logic [14:0] RST_TAPE_COEF = 15'd16384;

   localparam int MODE_FREEZE = 0;
   localparam int MODE_TAPE   = 1;
   localparam int MODE_BYPASS = 2;

   localparam logic [31:0] ENV_RISE   = 32'd21474836;
   localparam logic [31:0] ENV_FALL   = 32'd429497;
   localparam logic [23:0] ENV_ONSET  = 24'd167772;
   localparam logic [32:0] GAIN_ONE   = 33'h1_0000_0000 >> 1;
   localparam logic [31:0] AP_GAIN    = 32'd22938;
   localparam logic [31:0] TAPE_DRIVE = 32'd42598;
   localparam logic [16:0] Q15_ONE    = 17'd32768;
   localparam int          RIGHT_OFFSET = 23;

   typedef enum logic [5:0] {
      ST_IDLE, ST_ENV_MUL, ST_ENV_ADD, ST_GAIN_MUL, ST_GAIN_ADD, ST_SEND_MUL, ST_SEND_SET,
      ST_CLEN_MUL, ST_CLEN_ADDR, ST_CREAD, ST_CDAMP_A, ST_CDAMP_B, ST_CDAMP_SUM,
      ST_CFB_MUL, ST_CWRITE, ST_DIV, ST_DIV_SIGN, ST_ALEN_MUL, ST_ALEN_ADDR, ST_AREAD,
      ST_AMUL_Y, ST_AOUT, ST_AMUL_O, ST_AWRITE, ST_TDRIVE_MUL, ST_TDRIVE_SET, ST_TLP_MUL,
      ST_TLP_ADD, ST_OUT_SET, ST_TANH_MUL, ST_TANH_ADD, ST_CH_END, ST_DONE
   } state_type;

   function automatic logic [10:0] comb_base(input int i);
      case (i & 3)
         0:       return 11'd1557;
         1:       return 11'd1617;
         2:       return 11'd1491;
         default: return 11'd1422;
      endcase
   endfunction

   function automatic logic [10:0] ap_base(input int i);
      case (i & 1)
         0:       return 11'd225;
         default: return 11'd556;
      endcase
   endfunction

   function automatic logic [22:0] tanh_entry(input logic [4:0] k);
      case (k)
         5'd0:    return 23'd0;
         5'd1:    return 23'd2054527;
         5'd2:    return 23'd3876520;
         5'd3:    return 23'd5328016;
         5'd4:    return 23'd6388715;
         5'd5:    return 23'd7115919;
         5'd6:    return 23'd7592934;
         5'd7:    return 23'd7896829;
         5'd8:    return 23'd8086849;
         5'd9:    return 23'd8204277;
         5'd10:   return 23'd8276321;
         5'd11:   return 23'd8320325;
         5'd12:   return 23'd8347124;
         5'd13:   return 23'd8363425;
         5'd14:   return 23'd8373324;
         5'd15:   return 23'd8379330;
         default: return 23'd8382982;
      endcase
   endfunction

   function automatic logic signed [65:0] rnd15(input logic signed [65:0] v);
      return (v + 66'sd16384) >>> 15;
   endfunction

   function automatic logic signed [65:0] rnd31(input logic signed [65:0] v);
      return (v + 66'sd1073741824) >>> 31;
   endfunction

endpackage

>>> sv/swell_schroeder_reverb_top.sv
// Swell reverb top level: envelope swell, two Schroeder tanks, tape stage and tanh limiter.
//
// Usage: a stereo word enters on req_valid/req_ready with req_left_in and req_right_in
// (Q1.23). One result word leaves on rsp_valid/rsp_ready with the processed pair and
// the swell level. Registers are written through csr_write_enable, csr_index and
// csr_wdata; the user must write them only while the block is idle, which the block
// itself does not enforce. All arithmetic runs on one shared multiplier under a
// sequencer. The comb loop takes eight sequencer steps per comb. Bypass words go from
// idle straight to the done state. req_ready is high only when the sequencer is idle.
// The result sits in an output register; the next word is accepted while it waits,
// and the sequencer holds its finished word until the receiver takes the previous.
// Synchronous reset clears the filter state, pointers and registers to defaults.
// Delay lines need no clearing pass: a read of a line position not yet written since
// reset returns zero, tracked by shared comb and allpass write pointers and wrap flags.
module swell_schroeder_reverb_top #(
   parameter int COMB_DEPTH    = ssrv_pkg::DEF_COMB_DEPTH,
   parameter int ALLPASS_DEPTH = ssrv_pkg::DEF_ALLPASS_DEPTH,
   parameter int NUM_COMBS     = ssrv_pkg::DEF_NUM_COMBS,
   parameter int NUM_ALLPASSES = ssrv_pkg::DEF_NUM_ALLPASSES,
   parameter int SAMPLE_BITS   = ssrv_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ssrv_pkg::IO_W-1:0]    req_left_in,
   input  logic signed [ssrv_pkg::IO_W-1:0]    req_right_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssrv_pkg::IO_W-1:0]    rsp_left_out,
   output logic signed [ssrv_pkg::IO_W-1:0]    rsp_right_out,
   output logic        [ssrv_pkg::LVL_W-1:0]   rsp_swell_level,
   input  logic                                csr_write_enable,
   input  logic        [ssrv_pkg::CIDX_W-1:0]  csr_index,
   input  logic        [ssrv_pkg::CFG_W-1:0]   csr_wdata
);
   import ssrv_pkg::*;

   localparam int NL_C = 2 * NUM_COMBS;
   localparam int NL_A = 2 * NUM_ALLPASSES;
   localparam int CAW  = $clog2(COMB_DEPTH);
   localparam int AAW  = $clog2(ALLPASS_DEPTH);
   localparam int CLW  = $clog2(NL_C);
   localparam int ALW  = $clog2(NL_A);
   localparam int CIW  = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
   localparam int AIW  = (NUM_ALLPASSES > 1) ? $clog2(NUM_ALLPASSES) : 1;
   localparam int SB   = SAMPLE_BITS;
   localparam int YW   = SAMPLE_BITS + 4;
   localparam int WW   = (SAMPLE_BITS > IO_W) ? SAMPLE_BITS : IO_W;
   localparam int TXW  = WW + 2;
   localparam logic signed [65:0] SMAX_W = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
   localparam logic signed [65:0] SMIN_W = -(66'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic signed [32:0] DIV_RECIP =
      33'(((64'd1 << 31) + 64'(NUM_COMBS - 1)) / 64'(NUM_COMBS));

   function automatic logic signed [SB-1:0] sat_s(input logic signed [65:0] v);
      if (v > SMAX_W) begin
         return SB'(SMAX_W);
      end else if (v < SMIN_W) begin
         return SB'(SMIN_W);
      end
      return SB'(v);
   endfunction

   state_type state_ff, state_in;

   logic [14:0] room_ff, fb_ff, dcoef_ff, tcoef_ff;
   logic [30:0] attack_ff, release_ff;
   logic [2:0]  mode_ff;

   logic signed [IO_W-1:0] xl_ff, xl_in, xr_ff, xr_in, mono_ff, mono_in;
   logic        [23:0]     env_ff, env_in;
   logic        [31:0]     gain_ff, gain_in;
   logic signed [IO_W-1:0] send_ff, send_in;
   logic signed [64:0]     prod_ff, acc_ff, acc_in;
   logic                   ch_ff, ch_in;
   logic [CIW-1:0]         ci_ff, ci_in;
   logic [AIW-1:0]         ai_ff, ai_in;
   logic [CAW-1:0]         caddr_ff, caddr_in, cptr_ff, cptr_in;
   logic [AAW-1:0]         aaddr_ff, aaddr_in, aptr_ff, aptr_in;
   logic                   cwrap_ff, cwrap_in, awrap_ff, awrap_in, rvalid_ff, rvalid_in;
   logic signed [SB-1:0]   crd_ff, ard_ff;
   logic signed [YW-1:0]   yacc_ff, yacc_in;
   logic signed [SB-1:0]   dm_ff, dm_in, y_ff, y_in, v_ff, v_in, o_ff, o_in;
   logic [YW-1:0]          dq_ff, dq_in;
   logic                   dneg_ff, dneg_in;
   logic signed [WW-1:0]   wet_ff, wet_in;
   logic signed [TXW-1:0]  tx_ff, tx_in;
   logic                   tneg_ff, tneg_in, tbig_ff, tbig_in, tret_ff, tret_in;
   logic [3:0]             tidx_ff, tidx_in;
   logic signed [IO_W-1:0] tres_ff, tres_in, wl_ff, wl_in, wr_ff, wr_in;
   logic signed [SB-1:0]   damp_ff [NL_C];
   logic signed [SB-1:0]   damp_in [NL_C];
   logic signed [IO_W-1:0] ts_ff [2];
   logic signed [IO_W-1:0] ts_in [2];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [IO_W-1:0] rl_ff, rl_in, rr_ff, rr_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;

   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] mul_p;

   logic signed [SB-1:0] comb_mem [NL_C][COMB_DEPTH];
   logic signed [SB-1:0] ap_mem [NL_A][ALLPASS_DEPTH];
   logic                 comb_we, ap_we;
   logic signed [SB-1:0] comb_wd, ap_wd;
   logic [CLW-1:0]       ck;
   logic [ALW-1:0]       ak;

   logic [24:0]          mag;
   logic signed [25:0]   env_diff;
   logic [TXW:0]         tax;
   logic                 can_out;

   assign ck      = CLW'(int'(ch_ff) * NUM_COMBS + int'(ci_ff));
   assign ak      = ALW'(int'(ch_ff) * NUM_ALLPASSES + int'(ai_ff));
   assign mul_p   = mul_a * mul_b;
   assign can_out = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mag = (mono_ff < 0) ? 25'(-26'(mono_ff)) : 25'(mono_ff);
      if (66'(mag) > SMAX_W) begin
         mag = 25'(SMAX_W);
      end
      env_diff = $signed({1'b0, mag}) - $signed({2'b0, env_ff});
      tax = tx_ff[TXW-1] ? (TXW+1)'(-(TXW+1)'(tx_ff)) : (TXW+1)'(tx_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = mode_ff[MODE_BYPASS] ? ST_DONE : ST_ENV_MUL;
            end
         end
         ST_ENV_MUL:    state_in = ST_ENV_ADD;
         ST_ENV_ADD:    state_in = ST_GAIN_MUL;
         ST_GAIN_MUL:   state_in = ST_GAIN_ADD;
         ST_GAIN_ADD:   state_in = ST_SEND_MUL;
         ST_SEND_MUL:   state_in = ST_SEND_SET;
         ST_SEND_SET:   state_in = ST_CLEN_MUL;
         ST_CLEN_MUL:   state_in = ST_CLEN_ADDR;
         ST_CLEN_ADDR:  state_in = ST_CREAD;
         ST_CREAD:      state_in = ST_CDAMP_A;
         ST_CDAMP_A:    state_in = ST_CDAMP_B;
         ST_CDAMP_B:    state_in = ST_CDAMP_SUM;
         ST_CDAMP_SUM:  state_in = ST_CFB_MUL;
         ST_CFB_MUL:    state_in = ST_CWRITE;
         ST_CWRITE: begin
            state_in = (ci_ff == CIW'(NUM_COMBS - 1)) ? ST_DIV : ST_CLEN_MUL;
         end
         ST_DIV:        state_in = ST_DIV_SIGN;
         ST_DIV_SIGN:   state_in = ST_ALEN_MUL;
         ST_ALEN_MUL:   state_in = ST_ALEN_ADDR;
         ST_ALEN_ADDR:  state_in = ST_AREAD;
         ST_AREAD:      state_in = ST_AMUL_Y;
         ST_AMUL_Y:     state_in = ST_AOUT;
         ST_AOUT:       state_in = ST_AMUL_O;
         ST_AMUL_O:     state_in = ST_AWRITE;
         ST_AWRITE: begin
            if (ai_ff != AIW'(NUM_ALLPASSES - 1)) begin
               state_in = ST_ALEN_MUL;
            end else begin
               state_in = mode_ff[MODE_TAPE] ? ST_TDRIVE_MUL : ST_OUT_SET;
            end
         end
         ST_TDRIVE_MUL: state_in = ST_TDRIVE_SET;
         ST_TDRIVE_SET: state_in = ST_TANH_MUL;
         ST_TLP_MUL:    state_in = ST_TLP_ADD;
         ST_TLP_ADD:    state_in = ST_OUT_SET;
         ST_OUT_SET:    state_in = ST_TANH_MUL;
         ST_TANH_MUL:   state_in = ST_TANH_ADD;
         ST_TANH_ADD:   state_in = tret_ff ? ST_CH_END : ST_TLP_MUL;
         ST_CH_END:     state_in = ch_ff ? ST_DONE : ST_CLEN_MUL;
         ST_DONE: begin
            if (can_out) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ENV_MUL: begin
            mul_a = 33'(env_diff);
            mul_b = $signed((env_diff > 0) ? ENV_RISE : ENV_FALL);
         end
         ST_GAIN_MUL: begin
            mul_a = $signed(((env_ff > ENV_ONSET) ? GAIN_ONE : 33'd0) - {1'b0, gain_ff});
            mul_b = $signed({1'b0, (GAIN_ONE > {1'b0, gain_ff} && env_ff > ENV_ONSET) ?
                                   attack_ff : release_ff});
         end
         ST_SEND_MUL: begin
            mul_a = $signed({1'b0, gain_ff});
            mul_b = 32'(mono_ff);
         end
         ST_CLEN_MUL: begin
            mul_a = $signed({22'b0, comb_base(int'(ci_ff))});
            mul_b = $signed({17'b0, room_ff});
         end
         ST_ALEN_MUL: begin
            mul_a = $signed({22'b0, ap_base(int'(ai_ff))});
            mul_b = $signed({17'b0, room_ff});
         end
         ST_CDAMP_A: begin
            mul_a = rvalid_ff ? 33'(crd_ff) : 33'sd0;
            mul_b = $signed({15'b0, Q15_ONE - {2'b0, dcoef_ff}});
         end
         ST_CDAMP_B: begin
            mul_a = 33'(damp_ff[ck]);
            mul_b = $signed({17'b0, dcoef_ff});
         end
         ST_CFB_MUL: begin
            mul_a = 33'(dm_ff);
            mul_b = $signed({17'b0, fb_ff});
         end
         ST_DIV: begin
            mul_a = DIV_RECIP;
            mul_b = $signed(32'(dq_ff));
         end
         ST_AMUL_Y: begin
            mul_a = $signed({1'b0, AP_GAIN});
            mul_b = 32'(y_ff);
         end
         ST_AMUL_O: begin
            mul_a = $signed({1'b0, AP_GAIN});
            mul_b = 32'(o_ff);
         end
         ST_TDRIVE_MUL: begin
            mul_a = $signed({1'b0, TAPE_DRIVE});
            mul_b = 32'(y_ff);
         end
         ST_TANH_MUL: begin
            mul_a = $signed({10'b0, tanh_entry({1'b0, tax[24:21]} + 5'd1) -
                                    tanh_entry({1'b0, tax[24:21]})});
            mul_b = $signed({11'b0, tax[20:0]});
         end
         ST_TLP_MUL: begin
            mul_a = $signed({18'b0, tcoef_ff});
            mul_b = 32'(26'(tres_ff) - 26'(ts_ff[ch_ff]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic signed [65:0] t66;
      logic [YW-1:0]      amag;
      logic signed [WW+2:0] s3;
      logic [23:0]        tr;
      xl_in = xl_ff;  xr_in = xr_ff;  mono_in = mono_ff;
      env_in = env_ff;  gain_in = gain_ff;  send_in = send_ff;  acc_in = acc_ff;
      ch_in = ch_ff;  ci_in = ci_ff;  ai_in = ai_ff;
      caddr_in = caddr_ff;  aaddr_in = aaddr_ff;  cptr_in = cptr_ff;  aptr_in = aptr_ff;
      cwrap_in = cwrap_ff;  awrap_in = awrap_ff;  rvalid_in = rvalid_ff;
      yacc_in = yacc_ff;  dm_in = dm_ff;  y_in = y_ff;  v_in = v_ff;  o_in = o_ff;
      dq_in = dq_ff;  dneg_in = dneg_ff;
      wet_in = wet_ff;  tx_in = tx_ff;  tneg_in = tneg_ff;  tbig_in = tbig_ff;
      tret_in = tret_ff;  tidx_in = tidx_ff;  tres_in = tres_ff;
      wl_in = wl_ff;  wr_in = wr_ff;
      damp_in = damp_ff;  ts_in = ts_ff;
      rl_in = rl_ff;  rr_in = rr_ff;  lvl_in = lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      comb_we = 1'b0;  comb_wd = '0;  ap_we = 1'b0;  ap_wd = '0;
      t66 = '0;  amag = '0;  s3 = '0;  tr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xl_in   = req_left_in;
               xr_in   = req_right_in;
               mono_in = IO_W'((25'(req_left_in) + 25'(req_right_in)) >>> 1);
               wl_in   = req_left_in;
               wr_in   = req_right_in;
               ch_in   = 1'b0;
               ci_in   = '0;
               yacc_in = '0;
            end
         end
         ST_ENV_ADD: env_in = 24'($signed({42'b0, env_ff}) + rnd31(66'(prod_ff)));
         ST_GAIN_ADD: gain_in = 32'($signed({34'b0, gain_ff}) + rnd31(66'(prod_ff)));
         ST_SEND_SET: begin
            send_in = mode_ff[MODE_FREEZE] ? '0 : IO_W'(rnd31(66'(prod_ff)));
         end
         ST_CLEN_ADDR, ST_ALEN_ADDR: begin
            t66 = ((66'(prod_ff) + 66'sd8192) >>> 14) + (ch_ff ? 66'sd23 : 66'sd0);
            if (state_ff == ST_CLEN_ADDR) begin
               if (t66 < 66'sd1) begin
                  t66 = 66'sd1;
               end else if (t66 > 66'(COMB_DEPTH - 1)) begin
                  t66 = 66'(COMB_DEPTH - 1);
               end
               rvalid_in = cwrap_ff || ({1'b0, cptr_ff} >= (CAW+1)'(t66));
               caddr_in = CAW'({1'b0, cptr_ff} + ((CAW+1)'(t66) > {1'b0, cptr_ff} ?
                          (CAW+1)'(COMB_DEPTH) : '0) - (CAW+1)'(t66));
            end else begin
               if (t66 < 66'sd1) begin
                  t66 = 66'sd1;
               end else if (t66 > 66'(ALLPASS_DEPTH - 1)) begin
                  t66 = 66'(ALLPASS_DEPTH - 1);
               end
               rvalid_in = awrap_ff || ({1'b0, aptr_ff} >= (AAW+1)'(t66));
               aaddr_in = AAW'({1'b0, aptr_ff} + ((AAW+1)'(t66) > {1'b0, aptr_ff} ?
                          (AAW+1)'(ALLPASS_DEPTH) : '0) - (AAW+1)'(t66));
            end
         end
         ST_CDAMP_A: yacc_in = yacc_ff + (rvalid_ff ? YW'(crd_ff) : '0);
         ST_CDAMP_B: acc_in = prod_ff;
         ST_CDAMP_SUM: begin
            dm_in = sat_s(rnd15(66'(acc_ff) + 66'(prod_ff)));
            damp_in[ck] = dm_in;
         end
         ST_CWRITE: begin
            comb_we = 1'b1;
            comb_wd = sat_s(66'(send_ff) + rnd15(66'(prod_ff)));
            ci_in = ci_ff + 1'b1;
            amag = (yacc_ff < 0) ? YW'(-yacc_ff) : YW'(yacc_ff);
            dq_in = amag;
            dneg_in = yacc_ff < 0;
         end
         ST_DIV_SIGN: begin
            y_in = SB'(dneg_ff ? -(prod_ff >>> 31) : (prod_ff >>> 31));
            ai_in = '0;
         end
         ST_AMUL_Y: v_in = rvalid_ff ? ard_ff : '0;
         ST_AOUT: o_in = sat_s(66'(v_ff) - rnd15(66'(prod_ff)));
         ST_AWRITE: begin
            ap_we = 1'b1;
            ap_wd = sat_s(66'(y_ff) + rnd15(66'(prod_ff)));
            y_in = o_ff;
            wet_in = WW'(o_ff);
            ai_in = ai_ff + 1'b1;
         end
         ST_TDRIVE_SET: begin
            tx_in = TXW'(rnd15(66'(prod_ff)));
            tret_in = 1'b0;
         end
         ST_TLP_ADD: begin
            ts_in[ch_ff] = IO_W'(66'(ts_ff[ch_ff]) + rnd15(66'(prod_ff)));
            wet_in = WW'(ts_in[ch_ff]);
         end
         ST_OUT_SET: begin
            s3 = (WW+3)'(wet_ff) + ((WW+3)'(wet_ff) <<< 1) + (WW+3)'(1);
            tx_in = TXW'(s3 >>> 1);
            tret_in = 1'b1;
         end
         ST_TANH_MUL: begin
            tneg_in = tx_ff[TXW-1];
            tbig_in = tax[TXW:21] >= (TXW-20)'(16);
            tidx_in = tax[24:21];
         end
         ST_TANH_ADD: begin
            tr = tbig_ff ? {1'b0, tanh_entry(5'd16)} :
                           {1'b0, tanh_entry({1'b0, tidx_ff})} + 24'(prod_ff[43:21]);
            tres_in = tneg_ff ? -$signed(tr) : $signed(tr);
         end
         ST_CH_END: begin
            if (ch_ff) begin
               wr_in = tres_ff;
               cptr_in = (cptr_ff == CAW'(COMB_DEPTH - 1)) ? '0 : cptr_ff + 1'b1;
               aptr_in = (aptr_ff == AAW'(ALLPASS_DEPTH - 1)) ? '0 : aptr_ff + 1'b1;
               cwrap_in = cwrap_ff || (cptr_ff == CAW'(COMB_DEPTH - 1));
               awrap_in = awrap_ff || (aptr_ff == AAW'(ALLPASS_DEPTH - 1));
            end else begin
               wl_in = tres_ff;
               ch_in = 1'b1;
               ci_in = '0;
               yacc_in = '0;
            end
         end
         ST_DONE: begin
            if (can_out) begin
               rsp_valid_in = 1'b1;
               rl_in = wl_ff;
               rr_in = wr_ff;
               lvl_in = (gain_ff[31:15] > 17'd65535) ? 16'hFFFF : gain_ff[30:15];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (comb_we) begin
         comb_mem[ck][cptr_ff] <= comb_wd;
      end
      crd_ff <= comb_mem[ck][caddr_ff];
   end

   always_ff @(posedge clock) begin
      if (ap_we) begin
         ap_mem[ak][aptr_ff] <= ap_wd;
      end
      ard_ff <= ap_mem[ak][aaddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         room_ff      <= RST_ROOM;
         fb_ff        <= RST_FEEDBACK;
         dcoef_ff     <= RST_DAMPING;
         attack_ff    <= RST_ATTACK;
         release_ff   <= RST_RELEASE;
         mode_ff      <= RST_MODE;
         tcoef_ff     <= RST_TAPE_COEF;
         env_ff       <= '0;
         gain_ff      <= '0;
         cptr_ff      <= '0;
         aptr_ff      <= '0;
         cwrap_ff     <= 1'b0;
         awrap_ff     <= 1'b0;
         ch_ff        <= 1'b0;
         ci_ff        <= '0;
         ai_ff        <= '0;
         tret_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NL_C; i++) begin
            damp_ff[i] <= '0;
         end
         ts_ff[0]     <= '0;
         ts_ff[1]     <= '0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         cptr_ff      <= cptr_in;
         aptr_ff      <= aptr_in;
         cwrap_ff     <= cwrap_in;
         awrap_ff     <= awrap_in;
         ch_ff        <= ch_in;
         ci_ff        <= ci_in;
         ai_ff        <= ai_in;
         tret_ff      <= tret_in;
         rsp_valid_ff <= rsp_valid_in;
         damp_ff      <= damp_in;
         ts_ff        <= ts_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CFG_ROOM:      room_ff    <= csr_wdata[14:0];
               CFG_FEEDBACK:  fb_ff      <= csr_wdata[14:0];
               CFG_DAMPING:   dcoef_ff   <= csr_wdata[14:0];
               CFG_ATTACK:    attack_ff  <= csr_wdata;
               CFG_RELEASE:   release_ff <= csr_wdata;
               CFG_MODE:      mode_ff    <= csr_wdata[2:0];
               CFG_TAPE_COEF: tcoef_ff   <= csr_wdata[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      xl_ff     <= xl_in;
      xr_ff     <= xr_in;
      mono_ff   <= mono_in;
      send_ff   <= send_in;
      prod_ff   <= mul_p;
      acc_ff    <= acc_in;
      caddr_ff  <= caddr_in;
      aaddr_ff  <= aaddr_in;
      rvalid_ff <= rvalid_in;
      yacc_ff   <= yacc_in;
      dm_ff     <= dm_in;
      y_ff      <= y_in;
      v_ff      <= v_in;
      o_ff      <= o_in;
      dq_ff     <= dq_in;
      dneg_ff   <= dneg_in;
      wet_ff    <= wet_in;
      tx_ff     <= tx_in;
      tneg_ff   <= tneg_in;
      tbig_ff   <= tbig_in;
      tidx_ff   <= tidx_in;
      tres_ff   <= tres_in;
      wl_ff     <= wl_in;
      wr_ff     <= wr_in;
      rl_ff     <= rl_in;
      rr_ff     <= rr_in;
      lvl_ff    <= lvl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_out    = rl_ff;
   assign rsp_right_out   = rr_ff;
   assign rsp_swell_level = lvl_ff;

endmodule
